// ===== rtl/thermistor_adc_to_temperature_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the thermistor converter
// Concurrent assertion wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_TOP_MACROS_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define TAT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication checked in the same cycle.
`define TAT_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define TAT_ASSERT(lbl, clk, rst, prop, msg)
`define TAT_ASSERT_IMP(lbl, clk, rst, pre, post, msg)
`endif

`endif

// ===== rtl/tat_pkg.sv =====
// ----------------------------------------------------------------------------
// tat_pkg
// Widths, constants and codes shared by the thermistor converter files.
// ----------------------------------------------------------------------------
`default_nettype none

package tat_pkg;

   localparam int ADC_BITS_DEFAULT = 10;

   localparam int CODE_BITS   = 10;
   localparam int CHAN_BITS   = 2;
   localparam int TEMP_BITS   = 16;
   localparam int STATUS_BITS = 2;
   localparam int COEFF_BITS  = 48;
   localparam int OHMS_BITS   = 20;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 48;

   // Log unit: operands are normalized to [1,2) in Q30, 28 fraction bits of log2.
   localparam int X_BITS    = 20;
   localparam int K_BITS    = 5;
   localparam int M_BITS    = 31;
   localparam int FRAC_BITS = 28;
   localparam int LN2_BITS  = 28;
   localparam logic [LN2_BITS-1:0] LN2_Q28 = 28'd186065280;
   localparam int Q24_BITS  = 29;

   // Polynomial and reciprocal.
   localparam int L_BITS    = 32;
   localparam int ACC_BITS  = 64;
   localparam int Q_BITS    = 16;
   localparam logic [ACC_BITS-1:0] RECIP_NUMER = 64'd100 << 56;

   localparam int KELVIN_OFFSET_CENTI = 27315;
   localparam int TEMP_MAX_CENTI      = 25000;
   localparam int TEMP_MIN_CENTI      = -5500;

   localparam logic signed [COEFF_BITS-1:0] COEFF_A_RESET = 48'sd107711691567895;
   localparam logic signed [COEFF_BITS-1:0] COEFF_B_RESET = 48'sd15782054246187;
   localparam logic signed [COEFF_BITS-1:0] COEFF_C_RESET = 48'sd117014326958;
   localparam logic signed [COEFF_BITS-1:0] COEFF_D_RESET = 48'sd2482023827;
   localparam logic [OHMS_BITS-1:0]         SERIES_OHMS_RESET = 20'd4700;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_SHORT = 2'd1,
      STATUS_OPEN  = 2'd2,
      STATUS_SAT   = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEFF_A     = 3'd0,
      CSR_COEFF_B     = 3'd1,
      CSR_COEFF_C     = 3'd2,
      CSR_COEFF_D     = 3'd3,
      CSR_SERIES_OHMS = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

// ===== rtl/tat_req_if.sv =====
// ----------------------------------------------------------------------------
// tat_req_if
// Sample channel: one raw converter code with its channel tag per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tat_req_if;
   logic                           valid;
   logic                           ready;
   logic [tat_pkg::CODE_BITS-1:0]  adc_code;
   logic [tat_pkg::CHAN_BITS-1:0]  channel;

   modport source (output valid, output adc_code, output channel, input ready);
   modport sink   (input valid, input adc_code, input channel, output ready);
endinterface

`default_nettype wire

// ===== rtl/tat_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tat_rsp_if
// Result channel: temperature, channel tag and status per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tat_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tat_pkg::TEMP_BITS-1:0] temp_centi_c;
   logic [tat_pkg::CHAN_BITS-1:0]        channel_out;
   logic [tat_pkg::STATUS_BITS-1:0]      status;

   modport source (output valid, output temp_centi_c, output channel_out, output status,
                   input ready);
   modport sink   (input valid, input temp_centi_c, input channel_out, input status,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/thermistor_adc_to_temperature_top.sv =====
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_top
// NTC thermistor code to temperature in hundredths of a degree Celsius.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake       Contents
//   req_chan  in   valid / ready   adc_code, channel
//   rsp_chan  out  valid / ready   temp_centi_c, channel_out, status
//   csr_*     in   write enable    csr_index, csr_wdata (48 bits)
//
// One sample enters per clock while the output does not stall. The pipeline
// is made of the 28 square-and-compare steps of the log unit, the three
// four-stage Horner steps (each multiply is split into two partial products of
// the 32-bit halves) and the 16 restoring division steps of the reciprocal.
// Synchronous reset only clears the valid bits and restores the CSR defaults.
// A stage takes new data when it is empty or the stage after it moves, so a
// stalled result holds in place while empty stages upstream keep filling.
// Configuration writes are meant to arrive while the pipeline is empty.
//
`default_nettype none
`include "thermistor_adc_to_temperature_top_macros.svh"

module thermistor_adc_to_temperature_top #(
   parameter int ADC_BITS = tat_pkg::ADC_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   tat_req_if.sink                                 req_chan,
   tat_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_we,
   input  wire logic [tat_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [tat_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int X  = tat_pkg::X_BITS;
   localparam int M  = tat_pkg::M_BITS;
   localparam int KB = tat_pkg::K_BITS;
   localparam int FB = tat_pkg::FRAC_BITS;
   localparam int AB = tat_pkg::ACC_BITS;
   localparam int LB = tat_pkg::L_BITS;
   localparam int QB = tat_pkg::Q_BITS;
   localparam int CB = tat_pkg::COEFF_BITS;
   localparam int HALF = AB / 2;

   // Pipeline stage map.
   localparam int LOG_STEPS  = FB;
   localparam int S_LN       = LOG_STEPS + 1;
   localparam int S_L        = S_LN + 1;
   localparam int S_HZ       = S_L + 1;
   localparam int HZ_STAGES  = 4;
   localparam int HZ_TERMS   = 3;
   localparam int S_DIV      = S_HZ + HZ_TERMS * HZ_STAGES;
   localparam int S_OUT      = S_DIV + QB + 1;
   localparam int NS         = S_OUT + 1;

   localparam int LANES      = 3;
   localparam int LANE_CODE  = 0;
   localparam int LANE_OHMS  = 1;
   localparam int LANE_DIFF  = 2;

   localparam logic [X-1:0] FULL_X = X'((1 << ADC_BITS) - 1);

   localparam int PB  = KB + FB + tat_pkg::LN2_BITS;
   localparam int TCB = QB + 2;
   localparam logic signed [TCB-1:0] TC_OFFSET = TCB'(tat_pkg::KELVIN_OFFSET_CENTI);
   localparam logic signed [TCB-1:0] TC_MAX    = TCB'(tat_pkg::TEMP_MAX_CENTI);
   localparam logic signed [TCB-1:0] TC_MIN    = TCB'(tat_pkg::TEMP_MIN_CENTI);

   typedef struct packed {
      logic [tat_pkg::CHAN_BITS-1:0] channel;
      tat_pkg::status_type           status;
   } tag_type;

   typedef struct packed {
      logic [KB-1:0] k;
      logic [M-1:0]  m;
      logic [FB-1:0] frac;
   } lane_type;

   typedef struct packed {
      logic [AB-1:0] mag;
      logic [LB-1:0] lmag;
      logic          neg;
      logic [LB-1:0] l;
   } hz_a_type;

   typedef struct packed {
      logic [AB-1:0] plo;
      logic [AB-1:0] phi;
      logic          neg;
      logic [LB-1:0] l;
   } hz_b_type;

   typedef struct packed {
      logic [AB-1:0] r;
      logic          neg;
      logic [LB-1:0] l;
   } hz_c_type;

   typedef struct packed {
      logic [AB-1:0] acc;
      logic [LB-1:0] l;
   } hz_d_type;

   typedef struct packed {
      logic [AB-1:0]   rem;
      logic [AB-2:0]   den;
      logic [QB-1:0]   q;
      logic            sat_hi;
   } dv_type;

   typedef struct packed {
      logic signed [tat_pkg::TEMP_BITS-1:0] temp;
      logic [tat_pkg::CHAN_BITS-1:0]        channel;
      tat_pkg::status_type                  status;
   } out_type;

   // Configuration registers.
   logic signed [CB-1:0]                 coeff_a_ff, coeff_b_ff, coeff_c_ff, coeff_d_ff;
   logic [tat_pkg::OHMS_BITS-1:0]        series_ohms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_a_ff     <= tat_pkg::COEFF_A_RESET;
         coeff_b_ff     <= tat_pkg::COEFF_B_RESET;
         coeff_c_ff     <= tat_pkg::COEFF_C_RESET;
         coeff_d_ff     <= tat_pkg::COEFF_D_RESET;
         series_ohms_ff <= tat_pkg::SERIES_OHMS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tat_pkg::CSR_COEFF_A:     coeff_a_ff     <= csr_wdata[CB-1:0];
            tat_pkg::CSR_COEFF_B:     coeff_b_ff     <= csr_wdata[CB-1:0];
            tat_pkg::CSR_COEFF_C:     coeff_c_ff     <= csr_wdata[CB-1:0];
            tat_pkg::CSR_COEFF_D:     coeff_d_ff     <= csr_wdata[CB-1:0];
            tat_pkg::CSR_SERIES_OHMS: series_ohms_ff <= csr_wdata[tat_pkg::OHMS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Valid bits and the per-stage load chain. A stage loads when it is empty
   // or when the stage after it loads.
   logic [NS-1:0] v_ff;
   logic [NS:0]   load;

   assign load[NS] = rsp_chan.ready;
   for (genvar i = 0; i < NS; i++) begin : g_load
      assign load[i] = !v_ff[i] || load[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (load[NS-1:0] & {v_ff[NS-2:0], req_chan.valid}) | (~load[NS-1:0] & v_ff);
      end
   end

   assign req_chan.ready = load[0];

   tag_type  tag_ff  [0:NS-2];
   lane_type lg_ff   [0:LOG_STEPS][0:LANES-1];
   logic [tat_pkg::Q24_BITS-1:0] q24_ff [0:LANES-1];
   logic [LB-1:0] l_ff;
   hz_a_type hz_a_ff [0:HZ_TERMS-1];
   hz_b_type hz_b_ff [0:HZ_TERMS-1];
   hz_c_type hz_c_ff [0:HZ_TERMS-1];
   hz_d_type hz_d_ff [0:HZ_TERMS-1];
   dv_type   dv_ff   [0:QB];
   out_type  out_ff;

   // Leading-one search and shift so the mantissa sits in [2^30, 2^31).
   function automatic lane_type normalize(input logic [X-1:0] x);
      lane_type r;
      r.k = '0;
      for (int i = 0; i < X; i++) begin
         if (x[i]) begin
            r.k = KB'(i);
         end
      end
      r.m    = M'(x) << (KB'(M - 1) - r.k);
      r.frac = '0;
      return r;
   endfunction

   // Stage 0: input capture, sensor fault flags and normalization.
   logic [X-1:0] code_x, diff_x;
   tag_type      tag0;

   always_comb begin
      code_x       = X'(req_chan.adc_code) & FULL_X;
      diff_x       = FULL_X - code_x;
      tag0.channel = req_chan.channel;
      if (code_x == '0 || series_ohms_ff == '0) begin
         tag0.status = tat_pkg::STATUS_SHORT;
      end else if (code_x == FULL_X) begin
         tag0.status = tat_pkg::STATUS_OPEN;
      end else begin
         tag0.status = tat_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         tag_ff[0]           <= tag0;
         lg_ff[0][LANE_CODE] <= normalize(code_x);
         lg_ff[0][LANE_OHMS] <= normalize(X'(series_ohms_ff));
         lg_ff[0][LANE_DIFF] <= normalize(diff_x);
      end
   end

   // Tags ride along; a non-positive denominator is flagged at the divider.
   for (genvar i = 1; i < NS - 1; i++) begin : g_tag
      tag_type tag_in;
      always_comb begin
         tag_in = tag_ff[i-1];
         if (i == S_DIV) begin
            if (tag_ff[i-1].status == tat_pkg::STATUS_OK &&
                (hz_d_ff[HZ_TERMS-1].acc[AB-1] || hz_d_ff[HZ_TERMS-1].acc == '0)) begin
               tag_in.status = tat_pkg::STATUS_SAT;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (load[i]) begin
            tag_ff[i] <= tag_in;
         end
      end
   end

   // Log2 by repeated squaring: each step squares the mantissa and takes one
   // fraction bit when the square reaches two.
   for (genvar j = 1; j <= LOG_STEPS; j++) begin : g_log
      for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
         logic [2*M-1:0] sq;
         logic [M:0]     t;
         lane_type       nxt;
         always_comb begin
            sq  = (2*M)'(lg_ff[j-1][ln].m) * (2*M)'(lg_ff[j-1][ln].m);
            t   = sq[2*M-1:M-1];
            nxt = lg_ff[j-1][ln];
            if (t[M]) begin
               nxt.m           = t[M:1];
               nxt.frac[FB-j]  = 1'b1;
            end else begin
               nxt.m = t[M-1:0];
            end
         end
         always_ff @(posedge clock) begin
            if (load[j]) begin
               lg_ff[j][ln] <= nxt;
            end
         end
      end
   end

   // Scale log2 in Q28 by ln 2 and round to Q24.
   for (genvar ln = 0; ln < LANES; ln++) begin : g_ln
      logic [PB-1:0] prod;
      always_comb begin
         prod = PB'({lg_ff[LOG_STEPS][ln].k, lg_ff[LOG_STEPS][ln].frac}) *
                PB'(tat_pkg::LN2_Q28);
         prod = prod + (PB'(1) << 31);
      end
      always_ff @(posedge clock) begin
         if (load[S_LN]) begin
            q24_ff[ln] <= prod[32 +: tat_pkg::Q24_BITS];
         end
      end
   end

   // ln R = ln code + ln series - ln (full - code).
   always_ff @(posedge clock) begin
      if (load[S_L]) begin
         l_ff <= LB'(q24_ff[LANE_CODE]) + LB'(q24_ff[LANE_OHMS]) - LB'(q24_ff[LANE_DIFF]);
      end
   end

   // Horner steps: magnitude, partial products, rounded shift, sign and add.
   for (genvar h = 0; h < HZ_TERMS; h++) begin : g_hz
      localparam int SB = S_HZ + HZ_STAGES * h;
      logic [AB-1:0] acc_src;
      logic [LB-1:0] l_src;
      logic [AB-1:0] coeff_x;
      hz_a_type      a_in;
      hz_b_type      b_in;
      hz_c_type      c_in;
      hz_d_type      d_in;
      logic [AB+HALF-1:0] wide;

      if (h == 0) begin : g_first
         assign acc_src = {{(AB-CB){coeff_d_ff[CB-1]}}, coeff_d_ff};
         assign l_src   = l_ff;
         assign coeff_x = {{(AB-CB){coeff_c_ff[CB-1]}}, coeff_c_ff};
      end else begin : g_next
         assign acc_src = hz_d_ff[h-1].acc;
         assign l_src   = hz_d_ff[h-1].l;
         if (h == 1) begin : g_b
            assign coeff_x = {{(AB-CB){coeff_b_ff[CB-1]}}, coeff_b_ff};
         end else begin : g_a
            assign coeff_x = {{(AB-CB){coeff_a_ff[CB-1]}}, coeff_a_ff};
         end
      end

      always_comb begin
         a_in.mag  = acc_src[AB-1] ? (AB'(0) - acc_src) : acc_src;
         a_in.lmag = l_src[LB-1] ? (LB'(0) - l_src) : l_src;
         a_in.neg  = acc_src[AB-1] ^ l_src[LB-1];
         a_in.l    = l_src;

         b_in.plo  = AB'(hz_a_ff[h].mag[HALF-1:0]) * AB'(hz_a_ff[h].lmag);
         b_in.phi  = AB'(hz_a_ff[h].mag[AB-1:HALF]) * AB'(hz_a_ff[h].lmag);
         b_in.neg  = hz_a_ff[h].neg;
         b_in.l    = hz_a_ff[h].l;

         wide      = {hz_b_ff[h].phi, {HALF{1'b0}}} + (AB+HALF)'(hz_b_ff[h].plo) +
                     ((AB+HALF)'(1) << 23);
         c_in.r    = wide[24 +: AB];
         c_in.neg  = hz_b_ff[h].neg;
         c_in.l    = hz_b_ff[h].l;

         d_in.acc  = (hz_c_ff[h].neg ? (AB'(0) - hz_c_ff[h].r) : hz_c_ff[h].r) + coeff_x;
         d_in.l    = hz_c_ff[h].l;
      end

      always_ff @(posedge clock) begin
         if (load[SB]) begin
            hz_a_ff[h] <= a_in;
         end
         if (load[SB+1]) begin
            hz_b_ff[h] <= b_in;
         end
         if (load[SB+2]) begin
            hz_c_ff[h] <= c_in;
         end
         if (load[SB+3]) begin
            hz_d_ff[h] <= d_in;
         end
      end
   end

   // Reciprocal setup: rounded numerator, and a quotient that would need more
   // than 16 bits is already far above the upper clamp.
   dv_type dv0;
   always_comb begin
      dv0.den    = hz_d_ff[HZ_TERMS-1].acc[AB-2:0];
      dv0.rem    = tat_pkg::RECIP_NUMER + AB'(dv0.den >> 1);
      dv0.q      = '0;
      dv0.sat_hi = (AB+QB)'(dv0.rem) >= ((AB+QB)'(dv0.den) << QB);
   end

   always_ff @(posedge clock) begin
      if (load[S_DIV]) begin
         dv_ff[0] <= dv0;
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar n = 1; n <= QB; n++) begin : g_div
      localparam int B = QB - n;
      logic [AB+QB-1:0] trial;
      dv_type           nxt;
      always_comb begin
         trial = (AB+QB)'(dv_ff[n-1].den) << B;
         nxt   = dv_ff[n-1];
         if ((AB+QB)'(dv_ff[n-1].rem) >= trial) begin
            nxt.rem  = dv_ff[n-1].rem - trial[AB-1:0];
            nxt.q[B] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (load[S_DIV+n]) begin
            dv_ff[n] <= nxt;
         end
      end
   end

   // Kelvin to Celsius, clamp and final status.
   logic signed [TCB-1:0] tc;
   out_type               out_in;

   always_comb begin
      tc             = $signed({2'b00, dv_ff[QB].q}) - TC_OFFSET;
      out_in.channel = tag_ff[NS-2].channel;
      out_in.status  = tag_ff[NS-2].status;
      out_in.temp    = '0;
      if (tag_ff[NS-2].status == tat_pkg::STATUS_OK) begin
         if (dv_ff[QB].sat_hi || tc > TC_MAX) begin
            out_in.temp   = tat_pkg::TEMP_BITS'(TC_MAX);
            out_in.status = tat_pkg::STATUS_SAT;
         end else if (tc < TC_MIN) begin
            out_in.temp   = tat_pkg::TEMP_BITS'(TC_MIN);
            out_in.status = tat_pkg::STATUS_SAT;
         end else begin
            out_in.temp   = tc[tat_pkg::TEMP_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[S_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid        = v_ff[S_OUT];
   assign rsp_chan.temp_centi_c = out_ff.temp;
   assign rsp_chan.channel_out  = out_ff.channel;
   assign rsp_chan.status       = out_ff.status;

   // Sensor faults report a zero temperature; a bad denominator reports zero as saturated.
   `TAT_ASSERT_IMP(a_fault_zero, clock, reset,
      rsp_chan.valid && (out_ff.status == tat_pkg::STATUS_SHORT ||
      out_ff.status == tat_pkg::STATUS_OPEN), out_ff.temp == '0, "fault with nonzero temp")
   // A good reading is always inside the clamp range.
   `TAT_ASSERT_IMP(a_ok_range, clock, reset,
      rsp_chan.valid && out_ff.status == tat_pkg::STATUS_OK,
      out_ff.temp <= tat_pkg::TEMP_BITS'(TC_MAX) && out_ff.temp >= tat_pkg::TEMP_BITS'(TC_MIN),
      "ok reading outside range")
   // A saturated reading is either zero or one of the two clamp bounds.
   `TAT_ASSERT_IMP(a_sat_bound, clock, reset,
      rsp_chan.valid && out_ff.status == tat_pkg::STATUS_SAT && out_ff.temp != '0,
      out_ff.temp == tat_pkg::TEMP_BITS'(TC_MAX) || out_ff.temp == tat_pkg::TEMP_BITS'(TC_MIN),
      "saturated reading not at a bound")
   // Input back-pressure only when every stage is full and the output stalls.
   `TAT_ASSERT_IMP(a_ready_full, clock, reset,
      !req_chan.ready, (&v_ff) && !rsp_chan.ready, "input stalled with room in the pipeline")

endmodule

`default_nettype wire

// ===== sim/thermistor_adc_to_temperature_top_tb.sv =====
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_top_tb
// Self-checking bench: random and corner converter codes go through the block
// under several coefficient and series resistor settings, with random stalls
// on both channels, and every result is checked against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

import tat_pkg::*;

typedef struct {
   logic [TEMP_BITS-1:0] temp;
   logic [CHAN_BITS-1:0] chan;
   status_type           st;
} temp_reading_type;

class temp_scoreboard;
   longint             coeff_q56[4];
   longint unsigned    series_r;
   temp_reading_type   pending_readings[$];
   int                 mismatches;
   int                 checked;

   function void load_reset();
      coeff_q56[0] = longint'(COEFF_A_RESET);
      coeff_q56[1] = longint'(COEFF_B_RESET);
      coeff_q56[2] = longint'(COEFF_C_RESET);
      coeff_q56[3] = longint'(COEFF_D_RESET);
      series_r     = 64'(SERIES_OHMS_RESET);
   endfunction

   function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] v);
      case (idx)
         CSR_COEFF_A:     coeff_q56[0] = longint'($signed(v));
         CSR_COEFF_B:     coeff_q56[1] = longint'($signed(v));
         CSR_COEFF_C:     coeff_q56[2] = longint'($signed(v));
         CSR_COEFF_D:     coeff_q56[3] = longint'($signed(v));
         CSR_SERIES_OHMS: series_r = 64'(v[OHMS_BITS-1:0]);
         default: ;
      endcase
   endfunction

   // Natural log in Q8.24 via normalized log2 with 28 squaring steps.
   function longint ln_q24(longint unsigned x);
      int              k;
      longint unsigned m;
      longint unsigned frac;
      longint unsigned l2;
      k = 0;
      frac = 0;
      while (k < 63 && (x >> (k + 1)) != 0) k++;
      m = x << (30 - k);
      for (int i = 1; i <= 28; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | (64'd1 << (28 - i));
         end
      end
      l2 = (longint'(k) << 28) + frac;
      return longint'((l2 * longint'(LN2_Q28) + (64'd1 << 31)) >> 32);
   endfunction

   // x*l/2^24 with the magnitude rounded half up and the sign put back.
   function longint scale_q24(longint x, longint l);
      logic            neg;
      longint unsigned ua;
      longint unsigned ub;
      logic [127:0]    prod;
      logic [63:0]     r;
      neg  = (x < 0) != (l < 0);
      ua   = (x < 0) ? -x : x;
      ub   = (l < 0) ? -l : l;
      prod = {64'd0, ua} * {64'd0, ub};
      prod = prod + (128'd1 << 23);
      r    = prod[87:24];
      if (neg) r = -r;
      return longint'(r);
   endfunction

   function void note_sample(logic [CODE_BITS-1:0] code, logic [CHAN_BITS-1:0] chan);
      temp_reading_type e;
      longint unsigned  full;
      longint           lnr;
      longint           acc;
      longint unsigned  q;
      longint           t;
      full = (64'd1 << ADC_BITS_DEFAULT) - 1;
      e.chan = chan;
      e.st   = STATUS_OK;
      t = 0;
      if (code == 0 || series_r == 0) begin
         e.st = STATUS_SHORT;
      end else if (code == full) begin
         e.st = STATUS_OPEN;
      end else begin
         lnr = ln_q24(code) + ln_q24(series_r) - ln_q24(full - code);
         acc = coeff_q56[3];
         acc = coeff_q56[2] + scale_q24(acc, lnr);
         acc = coeff_q56[1] + scale_q24(acc, lnr);
         acc = coeff_q56[0] + scale_q24(acc, lnr);
         if (acc <= 0) begin
            e.st = STATUS_SAT;
         end else begin
            q = ((64'd100 << 56) + longint'(acc) / 2) / longint'(acc);
            t = longint'(q) - KELVIN_OFFSET_CENTI;
            if (t > TEMP_MAX_CENTI) begin
               t = TEMP_MAX_CENTI;
               e.st = STATUS_SAT;
            end else if (t < TEMP_MIN_CENTI) begin
               t = TEMP_MIN_CENTI;
               e.st = STATUS_SAT;
            end
         end
      end
      e.temp = t[TEMP_BITS-1:0];
      pending_readings.push_back(e);
   endfunction

   function void check_reading(logic [TEMP_BITS-1:0] temp, logic [CHAN_BITS-1:0] chan,
                               logic [STATUS_BITS-1:0] st);
      temp_reading_type e;
      checked++;
      if (pending_readings.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: temp %0d chan %0d status %0d",
                     $signed(temp), chan, st);
         return;
      end
      e = pending_readings.pop_front();
      if (temp !== e.temp || chan !== e.chan || st !== e.st) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected temp %0d chan %0d status %0d, got %0d %0d %0d",
                     $signed(e.temp), e.chan, e.st, $signed(temp), chan, st);
      end
   endfunction

   function int pending();
      return pending_readings.size();
   endfunction
endclass

module thermistor_adc_to_temperature_top_tb;

   // The pipeline is 61 deep; this margin covers it when draining.
   localparam int DRAIN_CYCLES = 80;
   // An index past the last register; the block must ignore writes to it.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NO_REG = 3'd7;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   tat_req_if req_chan ();
   tat_rsp_if rsp_chan ();

   thermistor_adc_to_temperature_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   temp_scoreboard sb;
   bit             quiet;       // no idling on either side once set
   int             samples_sent;
   int             phases_run;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Generous watchdog well above the slowest legal run.
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   // The result side stalls in random bursts until the quiet part of the run.
   initial begin
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(9, 1)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(12, 1)) @(posedge clock);
         end
      end
   end

   // Every result transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_reading(rsp_chan.temp_centi_c, rsp_chan.channel_out, rsp_chan.status);
   end

   // Holds valid high across back-to-back transfers and lowers it only for a gap.
   task automatic send_sample(logic [CODE_BITS-1:0] code, logic [CHAN_BITS-1:0] chan);
      req_chan.valid    <= 1'b1;
      req_chan.adc_code <= code;
      req_chan.channel  <= chan;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_sample(code, chan);
      samples_sent++;
      if (!quiet && $urandom_range(3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(9, 1)) @(posedge clock);
      end
   endtask

   // The sender stops and waits until every result is back and the pipe is empty.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Back-to-back writes keep the enable high; end_writes drops it.
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic end_writes();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] rand48();
      return CSR_DATA_BITS'({$urandom, $urandom});
   endfunction

   function automatic logic [CODE_BITS-1:0] pick_code();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return CODE_BITS'($urandom_range(3, 1));
         3:       return CODE_BITS'($urandom_range(1022, 1019));
         default: return CODE_BITS'($urandom);
      endcase
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++)
         send_sample(pick_code(), CHAN_BITS'($urandom));
      drain();
      phases_run++;
   endtask

   // Coefficients close to the nominal set, so most results stay in range.
   task automatic write_near_nominal(logic [OHMS_BITS-1:0] ohms);
      write_reg(CSR_COEFF_A, COEFF_A_RESET + $signed(48'($urandom_range(2000000)) - 1000000));
      write_reg(CSR_COEFF_B, COEFF_B_RESET + $signed(48'($urandom_range(200000)) - 100000));
      write_reg(CSR_COEFF_C, COEFF_C_RESET + $signed(48'($urandom_range(20000)) - 10000));
      write_reg(CSR_COEFF_D, COEFF_D_RESET + $signed(48'($urandom_range(2000)) - 1000));
      write_reg(CSR_SERIES_OHMS, 48'(ohms));
      end_writes();
   endtask

   initial begin
      logic [CODE_BITS-1:0] corner_codes[10];
      sb = new();
      sb.load_reset();
      quiet = 1'b0;
      samples_sent = 0;
      phases_run = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.adc_code = '0;
      req_chan.channel = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings: short, open, the ends of the code
      // range next to them, mid scale, and every channel tag.
      corner_codes = '{10'd0, 10'd1, 10'd2, 10'd511, 10'd512, 10'd1021, 10'd1022,
                       10'd1023, 10'h2AA, 10'h155};
      foreach (corner_codes[i])
         send_sample(corner_codes[i], CHAN_BITS'(i));
      drain();

      // Smallest and largest series resistor, a zero resistor that reads as a
      // short, coefficient extremes, and a write to an unused index.
      write_reg(CSR_SERIES_OHMS, 48'd1);
      end_writes();
      send_sample(10'd1, 2'd0);
      send_sample(10'd512, 2'd1);
      send_sample(10'd1022, 2'd2);
      drain();
      write_reg(CSR_SERIES_OHMS, 48'hFFFFF);
      end_writes();
      send_sample(10'd1, 2'd3);
      send_sample(10'd1022, 2'd0);
      drain();
      write_reg(CSR_SERIES_OHMS, 48'd0);
      write_reg(CSR_NO_REG, rand48());
      end_writes();
      send_sample(10'd300, 2'd1);
      send_sample(10'd1023, 2'd2);
      drain();
      write_reg(CSR_COEFF_A, 48'h7FFF_FFFF_FFFF);
      write_reg(CSR_COEFF_B, 48'h8000_0000_0000);
      write_reg(CSR_COEFF_C, 48'h7FFF_FFFF_FFFF);
      write_reg(CSR_COEFF_D, 48'h8000_0000_0000);
      write_reg(CSR_SERIES_OHMS, 48'd4700);
      end_writes();
      send_sample(10'd100, 2'd3);
      send_sample(10'd900, 2'd0);
      drain();
      write_reg(CSR_COEFF_A, 48'h8000_0000_0000);
      write_reg(CSR_COEFF_B, 48'd0);
      write_reg(CSR_COEFF_C, 48'd0);
      write_reg(CSR_COEFF_D, 48'd0);
      end_writes();
      send_sample(10'd512, 2'd1);
      drain();

      // Random part: mostly plausible coefficient sets with random resistors,
      // one fully random set, and a quiet final stretch at nominal values.
      write_near_nominal(SERIES_OHMS_RESET);
      random_phase(200);
      write_near_nominal(OHMS_BITS'($urandom_range(100000, 1)));
      random_phase(200);
      write_near_nominal(OHMS_BITS'($urandom_range(1048575, 1)));
      random_phase(200);
      write_reg(CSR_COEFF_A, rand48());
      write_reg(CSR_COEFF_B, rand48());
      write_reg(CSR_COEFF_C, rand48());
      write_reg(CSR_COEFF_D, rand48());
      write_reg(CSR_SERIES_OHMS, rand48());
      end_writes();
      random_phase(150);
      write_near_nominal(OHMS_BITS'($urandom_range(1000, 10)));
      random_phase(200);
      write_reg(CSR_COEFF_A, COEFF_A_RESET);
      write_reg(CSR_COEFF_B, COEFF_B_RESET);
      write_reg(CSR_COEFF_C, COEFF_C_RESET);
      write_reg(CSR_COEFF_D, COEFF_D_RESET);
      write_reg(CSR_SERIES_OHMS, 48'(SERIES_OHMS_RESET));
      end_writes();
      quiet = 1'b1;
      random_phase(180);

      $display("covered %0d samples, %0d results checked, %0d random phases",
               samples_sent, sb.checked, phases_run);
      $display("settings ran from nominal to extreme coefficients and resistors");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
